@@ rtl/core/udp_header_filter_key_extract_defines.svh @@
// assertion macros for the udp header filter
`ifndef UDP_HEADER_FILTER_KEY_EXTRACT_DEFINES_SVH
`define UDP_HEADER_FILTER_KEY_EXTRACT_DEFINES_SVH
`ifndef SYNTHESIS
`define UHF_ASSERT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("uhf assertion failed");
`define UHF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("uhf assertion failed");
`else
`define UHF_ASSERT(lbl, clk, rst, ante, cons)
`define UHF_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ rtl/core/uhf_pkg.sv @@
// shared types and constants of the udp header filter
`timescale 1ns / 1ps
package uhf_pkg;

  localparam int HEAD_BEATS      = 8;
  localparam int HEAD_IDX_W      = $clog2(HEAD_BEATS);
  localparam int COUNT_W         = HEAD_IDX_W + 1;
  localparam int UHF_QUEUE_DEPTH = 4;
  localparam int REG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 32;

  localparam logic [23:0] ETH_IP_SIG = 24'h450008;
  localparam logic [7:0]  PROTO_UDP  = 8'h11;

  localparam logic KIND_BEAT = 1'b0;
  localparam logic KIND_KEY  = 1'b1;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SRC_IP   = 2'd0,
    REG_DST_IP   = 2'd1,
    REG_SRC_PORT = 2'd2,
    REG_DST_PORT = 2'd3
  } reg_idx_t;

  typedef enum logic {
    CMD_BEAT = 1'b0,
    CMD_DUMP = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [63:0] data;
    logic [7:0]  keep;
    logic        last;
  } head_entry_t;

  typedef struct packed {
    cmd_t        cmd;
    head_entry_t beat;
  } qent_t;

  typedef struct packed {
    logic [15:0] key_high;
    logic [63:0] key_low;
    head_entry_t entry;
  } head_view_t;

  typedef struct packed {
    logic [HEAD_IDX_W-1:0] idx;
    logic                  done;
  } dump_ctl_t;

  typedef struct packed {
    logic        kind;
    logic [63:0] data;
    logic [7:0]  keep;
    logic        last;
    logic [63:0] key_low;
    logic [15:0] key_high;
    logic        burst_end;
  } res_t;

endpackage

@@ rtl/core/uhf_front.sv @@
// front end: header capture, filter decision and command issue
`timescale 1ns / 1ps
`include "udp_header_filter_key_extract_defines.svh"
module uhf_front
  import uhf_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [63:0]           beat_data,
  input  logic [7:0]            beat_keep,
  input  logic                  beat_last,
  input  logic                  wr_en,
  input  logic [REG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data,
  output logic                  q_push,
  output qent_t                 q_entry,
  input  logic                  q_full,
  input  dump_ctl_t             dump_ctl,
  output head_view_t            head_view
);

  head_entry_t          head_mem [HEAD_BEATS];
  logic [COUNT_W-1:0]   beat_count;
  logic                 decided;
  logic                 passes;
  logic                 locked;
  logic [31:0]          src_ip;
  logic [31:0]          dst_ip;
  logic [15:0]          src_port;
  logic [15:0]          dst_port;

  logic                 accept;
  logic                 at_decide;
  logic                 match;
  logic                 push_beat;
  logic                 push_dump;
  head_entry_t          in_entry;
  logic [23:0]          sig;
  logic [7:0]           proto;
  logic [31:0]          got_src_ip;
  logic [31:0]          got_dst_ip;
  logic [15:0]          got_src_port;
  logic [15:0]          got_dst_port;

  assign in_entry  = '{data: beat_data, keep: beat_keep, last: beat_last};
  assign in_stall  = q_full || (locked && !decided);
  assign accept    = in_valid && !in_stall;
  assign at_decide = !decided && (beat_count == COUNT_W'(HEAD_BEATS - 1));

  // header fields, bytes taken from the held beats
  assign sig          = {head_mem[1].data[55:48], head_mem[1].data[47:40],
                         head_mem[1].data[39:32]};
  assign proto        = head_mem[2].data[63:56];
  assign got_src_ip   = {head_mem[3].data[23:16], head_mem[3].data[31:24],
                         head_mem[3].data[39:32], head_mem[3].data[47:40]};
  assign got_dst_ip   = {head_mem[3].data[55:48], head_mem[3].data[63:56],
                         head_mem[4].data[7:0],   head_mem[4].data[15:8]};
  assign got_src_port = {head_mem[4].data[23:16], head_mem[4].data[31:24]};
  assign got_dst_port = {head_mem[4].data[39:32], head_mem[4].data[47:40]};

  assign match = (sig == ETH_IP_SIG) && (proto == PROTO_UDP)
              && ((src_ip == '0)   || (got_src_ip == src_ip))
              && ((dst_ip == '0)   || (got_dst_ip == dst_ip))
              && ((src_port == '0) || (got_src_port == src_port))
              && ((dst_port == '0) || (got_dst_port == dst_port));

  assign push_beat = accept && decided && passes;
  assign push_dump = accept && at_decide && match;

  assign q_push        = push_beat || push_dump;
  assign q_entry.cmd   = push_dump ? CMD_DUMP : CMD_BEAT;
  assign q_entry.beat  = in_entry;

  assign head_view.key_high = {head_mem[5].data[63:56], head_mem[6].data[7:0]};
  assign head_view.key_low  = {head_mem[6].data[15:8],  head_mem[6].data[23:16],
                               head_mem[6].data[31:24], head_mem[6].data[39:32],
                               head_mem[6].data[47:40], head_mem[6].data[55:48],
                               head_mem[6].data[63:56], head_mem[7].data[7:0]};
  assign head_view.entry    = head_mem[dump_ctl.idx];

  always_ff @(posedge clk) begin
    if (accept && !decided) begin
      head_mem[beat_count[HEAD_IDX_W-1:0]] <= in_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_count <= '0;
      decided    <= 1'b0;
      passes     <= 1'b0;
      locked     <= 1'b0;
      src_ip     <= '0;
      dst_ip     <= '0;
      src_port   <= '0;
      dst_port   <= '0;
    end else begin
      if (wr_en) begin
        case (reg_idx_t'(wr_index))
          REG_SRC_IP:   src_ip   <= wr_data;
          REG_DST_IP:   dst_ip   <= wr_data;
          REG_SRC_PORT: src_port <= wr_data[15:0];
          REG_DST_PORT: dst_port <= wr_data[15:0];
          default: ;
        endcase
      end
      if (push_dump) begin
        locked <= 1'b1;
      end else if (dump_ctl.done) begin
        locked <= 1'b0;
      end
      if (accept) begin
        if (beat_last) begin
          beat_count <= '0;
          decided    <= 1'b0;
          passes     <= 1'b0;
        end else if (at_decide) begin
          beat_count <= COUNT_W'(HEAD_BEATS);
          decided    <= 1'b1;
          passes     <= match;
        end else if (!decided) begin
          beat_count <= beat_count + 1'b1;
        end
      end
    end
  end

  `UHF_ASSERT(a_no_push_full, clk, rst, q_push, !q_full)
  `UHF_ASSERT(a_decided_count, clk, rst, decided, beat_count == COUNT_W'(HEAD_BEATS))
  `UHF_ASSERT(a_open_count, clk, rst, !decided, !beat_count[HEAD_IDX_W])

endmodule

@@ rtl/core/uhf_queue.sv @@
// command queue between the front and back ends
`timescale 1ns / 1ps
module uhf_queue
  import uhf_pkg::*;
#(
  parameter int DEPTH = UHF_QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  qent_t push_entry,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output qent_t pop_entry
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  qent_t          mem [DEPTH];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full      = (count == CW'(DEPTH));
  assign empty     = (count == '0);
  assign pop_entry = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/core/uhf_back.sv @@
// back end: beat pass-through, key and held-beat replay, output register
`timescale 1ns / 1ps
`include "udp_header_filter_key_extract_defines.svh"
module uhf_back
  import uhf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  qent_t      q_entry,
  output logic       q_pop,
  input  head_view_t head_view,
  output dump_ctl_t  dump_ctl,
  output logic       out_valid,
  input  logic       out_stall,
  output res_t       res
);

  typedef enum logic [1:0] {
    S_PASS = 2'b01,
    S_HEAD = 2'b10
  } state_t;

  state_t                state;
  state_t                state_next;
  logic [HEAD_IDX_W-1:0] idx;
  logic [HEAD_IDX_W-1:0] idx_next;
  logic                  load;
  logic                  have;
  logic                  last_idx;
  res_t                  res_next;

  assign load     = !out_valid || !out_stall;
  assign last_idx = (idx == HEAD_IDX_W'(HEAD_BEATS - 1));

  always_comb begin
    res_next      = '0;
    have          = 1'b0;
    q_pop         = 1'b0;
    dump_ctl.idx  = idx;
    dump_ctl.done = 1'b0;
    state_next    = state;
    idx_next      = idx;
    case (state)
      S_PASS: begin
        if (!q_empty) begin
          have  = 1'b1;
          q_pop = load;
          if (q_entry.cmd == CMD_DUMP) begin
            res_next.kind     = KIND_KEY;
            res_next.key_low  = head_view.key_low;
            res_next.key_high = head_view.key_high;
            state_next        = S_HEAD;
            idx_next          = '0;
          end else begin
            res_next.kind      = KIND_BEAT;
            res_next.data      = q_entry.beat.data;
            res_next.keep      = q_entry.beat.keep;
            res_next.last      = q_entry.beat.last;
            res_next.burst_end = 1'b1;
          end
        end
      end
      S_HEAD: begin
        have               = 1'b1;
        res_next.kind      = KIND_BEAT;
        res_next.data      = head_view.entry.data;
        res_next.keep      = head_view.entry.keep;
        res_next.last      = head_view.entry.last;
        res_next.burst_end = last_idx;
        idx_next           = idx + 1'b1;
        if (last_idx) begin
          state_next    = S_PASS;
          dump_ctl.done = load;
        end
      end
      default: begin
        state_next = S_PASS;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_PASS;
      idx       <= '0;
      out_valid <= 1'b0;
    end else if (load) begin
      state     <= state_next;
      idx       <= idx_next;
      out_valid <= have;
    end
  end

  always_ff @(posedge clk) begin
    if (load && have) begin
      res <= res_next;
    end
  end

  `UHF_ASSERT(a_no_pop_in_dump, clk, rst, state == S_HEAD, !q_pop)
  `UHF_ASSERT_NEXT(a_dump_starts, clk, rst, q_pop && (q_entry.cmd == CMD_DUMP), state == S_HEAD)
  `UHF_ASSERT_NEXT(a_idx_holds, clk, rst, (state == S_HEAD) && !load, $stable(idx))

endmodule

@@ rtl/core/udp_header_filter_key_extract.sv @@
// top level of the udp/ipv4 header filter with key extraction
// a passed beat goes through the command queue and then the output register
// a passing frame's eighth beat queues a dump: the key, then eight held beats
// throughput: one beat per cycle while the queue has room; a new frame waits until
// the nine results are replayed, one per cycle from the header store when unstalled
// reset: synchronous, clears frame state, queue, output valid and filter registers
`timescale 1ns / 1ps
module udp_header_filter_key_extract
  import uhf_pkg::*;
#(
  parameter int QUEUE_DEPTH = UHF_QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [63:0]           beat_data,
  input  logic [7:0]            beat_keep,
  input  logic                  beat_last,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  item_kind,
  output logic [63:0]           out_data,
  output logic [7:0]            out_keep,
  output logic                  out_last,
  output logic [63:0]           key_low,
  output logic [15:0]           key_high,
  output logic                  burst_end,
  input  logic                  wr_en,
  input  logic [REG_IDX_W-1:0]  wr_index,
  input  logic [CFG_DATA_W-1:0] wr_data
);

  logic       q_push;
  logic       q_full;
  logic       q_pop;
  logic       q_empty;
  qent_t      q_in;
  qent_t      q_out;
  head_view_t head_view;
  dump_ctl_t  dump_ctl;
  res_t       res;

  uhf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .beat_data (beat_data),
    .beat_keep (beat_keep),
    .beat_last (beat_last),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .q_push    (q_push),
    .q_entry   (q_in),
    .q_full    (q_full),
    .dump_ctl  (dump_ctl),
    .head_view (head_view)
  );

  uhf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .empty      (q_empty),
    .pop_entry  (q_out)
  );

  uhf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_entry   (q_out),
    .q_pop     (q_pop),
    .head_view (head_view),
    .dump_ctl  (dump_ctl),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign item_kind = res.kind;
  assign out_data  = res.data;
  assign out_keep  = res.keep;
  assign out_last  = res.last;
  assign key_low   = res.key_low;
  assign key_high  = res.key_high;
  assign burst_end = res.burst_end;

endmodule

@@ bench/udp_header_filter_key_extract_test.sv @@
// self-checking testbench for the udp/ipv4 header filter with key extraction
`timescale 1ns / 1ps
module udp_header_filter_key_extract_test;
  import uhf_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 12;

  typedef enum int {
    FLAW_NONE,
    FLAW_ETHERTYPE,
    FLAW_VERSION,
    FLAW_PROTO,
    FLAW_SRC_IP,
    FLAW_DST_IP,
    FLAW_SRC_PORT,
    FLAW_DST_PORT,
    FLAW_NOISE
  } flaw_t;

  typedef enum int {
    FILL_RANDOM,
    FILL_ZERO,
    FILL_ONES
  } fill_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [63:0] beat_data = '0;
  logic [7:0] beat_keep = '0;
  logic beat_last = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic item_kind;
  logic [63:0] out_data;
  logic [7:0] out_keep;
  logic out_last;
  logic [63:0] key_low;
  logic [15:0] key_high;
  logic burst_end;
  logic wr_en = 1'b0;
  logic [REG_IDX_W-1:0] wr_index = '0;
  logic [CFG_DATA_W-1:0] wr_data = '0;

  udp_header_filter_key_extract uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .beat_data(beat_data),
    .beat_keep(beat_keep),
    .beat_last(beat_last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .item_kind(item_kind),
    .out_data(out_data),
    .out_keep(out_keep),
    .out_last(out_last),
    .key_low(key_low),
    .key_high(key_high),
    .burst_end(burst_end),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // filter model state
  logic [63:0] held_data [0:HEAD_BEATS-1];
  logic [7:0] held_keep [0:HEAD_BEATS-1];
  logic held_last [0:HEAD_BEATS-1];
  int held_count = 0;
  bit verdict_made = 1'b0;
  bit verdict_ok = 1'b0;
  logic [31:0] want_src_ip = '0;
  logic [31:0] want_dst_ip = '0;
  logic [15:0] want_src_port = '0;
  logic [15:0] want_dst_port = '0;

  res_t filtered_q [$];

  int errors = 0;
  int cycles = 0;
  int sent_beats = 0;
  int checked_results = 0;
  int filter_settings = 0;
  int rx_wait = 0;
  bit quiet = 1'b0;

  function automatic logic [7:0] head_byte(int n);
    return held_data[n / 8][8 * (n % 8) +: 8];
  endfunction

  function automatic res_t beat_result(logic [63:0] d, logic [7:0] k, logic l, logic e);
    res_t r;
    r = '0;
    r.kind = KIND_BEAT;
    r.data = d;
    r.keep = k;
    r.last = l;
    r.burst_end = e;
    return r;
  endfunction

  function automatic void track_frame_beat(logic [63:0] d, logic [7:0] k, logic l);
    res_t r;
    bit frame_ok;
    if (verdict_made) begin
      if (verdict_ok) filtered_q.push_back(beat_result(d, k, l, 1'b1));
    end else begin
      held_data[held_count] = d;
      held_keep[held_count] = k;
      held_last[held_count] = l;
      held_count++;
      if (held_count == HEAD_BEATS) begin
        frame_ok = ({head_byte(14), head_byte(13), head_byte(12)} == ETH_IP_SIG)
          && (head_byte(23) == PROTO_UDP)
          && (want_src_ip == 0 ||
              {head_byte(26), head_byte(27), head_byte(28), head_byte(29)} == want_src_ip)
          && (want_dst_ip == 0 ||
              {head_byte(30), head_byte(31), head_byte(32), head_byte(33)} == want_dst_ip)
          && (want_src_port == 0 || {head_byte(34), head_byte(35)} == want_src_port)
          && (want_dst_port == 0 || {head_byte(36), head_byte(37)} == want_dst_port);
        verdict_made = 1'b1;
        verdict_ok = frame_ok;
        if (frame_ok) begin
          r = '0;
          r.kind = KIND_KEY;
          r.key_high = {head_byte(47), head_byte(48)};
          for (int i = 49; i <= 56; i++) r.key_low = {r.key_low[55:0], head_byte(i)};
          filtered_q.push_back(r);
          for (int i = 0; i < HEAD_BEATS; i++)
            filtered_q.push_back(beat_result(held_data[i], held_keep[i], held_last[i],
                                             i == HEAD_BEATS - 1));
        end
      end
    end
    if (l) begin
      held_count = 0;
      verdict_made = 1'b0;
      verdict_ok = 1'b0;
    end
  endfunction

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  task automatic check_result();
    res_t want;
    if (filtered_q.size() == 0) begin
      $error("result with nothing expected: item_kind %0h out_data %0h", item_kind, out_data);
      errors++;
    end else begin
      want = filtered_q.pop_front();
      compare_field("item_kind", want.kind, item_kind);
      compare_field("out_data", want.data, out_data);
      compare_field("out_keep", want.keep, out_keep);
      compare_field("out_last", want.last, out_last);
      compare_field("key_low", want.key_low, key_low);
      compare_field("key_high", want.key_high, key_high);
      compare_field("burst_end", want.burst_end, burst_end);
    end
    checked_results++;
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        check_result();
        rx_wait = quiet ? 0 : $urandom_range(0, 9);
      end else if (rx_wait > 0) begin
        rx_wait = rx_wait - 1;
      end
      out_stall <= (rx_wait != 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_beat(logic [63:0] d, logic [7:0] k, logic l);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    beat_data <= d;
    beat_keep <= k;
    beat_last <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_frame_beat(d, k, l);
    sent_beats++;
  endtask

  task automatic send_frame(int nbeats, flaw_t flaw, fill_t fill);
    logic [7:0] fb [0:127];
    logic [63:0] d;
    logic [7:0] k;
    logic [7:0] flip;
    int pos;
    for (int i = 0; i < 128; i++)
      fb[i] = (fill == FILL_ZERO) ? 8'h00 : (fill == FILL_ONES) ? 8'hff : 8'($urandom);
    if (flaw != FLAW_NOISE) begin
      fb[12] = ETH_IP_SIG[7:0];
      fb[13] = ETH_IP_SIG[15:8];
      fb[14] = ETH_IP_SIG[23:16];
      fb[23] = PROTO_UDP;
      if (want_src_ip != 0) {fb[26], fb[27], fb[28], fb[29]} = want_src_ip;
      if (want_dst_ip != 0) {fb[30], fb[31], fb[32], fb[33]} = want_dst_ip;
      if (want_src_port != 0) {fb[34], fb[35]} = want_src_port;
      if (want_dst_port != 0) {fb[36], fb[37]} = want_dst_port;
    end
    flip = 8'($urandom_range(1, 255));
    pos = -1;
    case (flaw)
      FLAW_ETHERTYPE: pos = 12 + $urandom_range(0, 1);
      FLAW_VERSION: pos = 14;
      FLAW_PROTO: pos = 23;
      FLAW_SRC_IP: pos = 26 + $urandom_range(0, 3);
      FLAW_DST_IP: pos = 30 + $urandom_range(0, 3);
      FLAW_SRC_PORT: pos = 34 + $urandom_range(0, 1);
      FLAW_DST_PORT: pos = 36 + $urandom_range(0, 1);
      default: pos = -1;
    endcase
    if (pos >= 0) fb[pos] = fb[pos] ^ flip;
    for (int b = 0; b < nbeats; b++) begin
      for (int i = 0; i < 8; i++) d[8 * i +: 8] = fb[8 * b + i];
      k = (fill == FILL_ZERO) ? 8'h00 : (fill == FILL_ONES) ? 8'hff : 8'($urandom);
      send_beat(d, k, b == nbeats - 1);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_filters(logic [31:0] src_ip, logic [31:0] dst_ip,
                             logic [15:0] src_port, logic [15:0] dst_port);
    wait_idle();
    wr_en <= 1'b1;
    wr_index <= REG_SRC_IP;
    wr_data <= src_ip;
    @(posedge clk);
    wr_index <= REG_DST_IP;
    wr_data <= dst_ip;
    @(posedge clk);
    // upper bits of a port write are ignored
    wr_index <= REG_SRC_PORT;
    wr_data <= {16'($urandom), src_port};
    @(posedge clk);
    wr_index <= REG_DST_PORT;
    wr_data <= {16'($urandom), dst_port};
    @(posedge clk);
    wr_en <= 1'b0;
    @(posedge clk);
    want_src_ip = src_ip;
    want_dst_ip = dst_ip;
    want_src_port = src_port;
    want_dst_port = dst_port;
    filter_settings++;
  endtask

  function automatic logic [31:0] pick_reg(int bits);
    logic [31:0] v;
    case ($urandom_range(0, 3))
      0: v = '0;
      1: v = '1;
      default: v = $urandom;
    endcase
    return (bits == 32) ? v : {16'h0, v[15:0]};
  endfunction

  // reset filters: short frame, exact eight-beat frame, longer frame
  task automatic test_directed_frames();
    send_frame(2, FLAW_NONE, FILL_ONES);
    send_frame(8, FLAW_NONE, FILL_ZERO);
    send_frame(9, FLAW_NONE, FILL_ONES);
  endtask

  task automatic test_header_checks();
    set_filters($urandom_range(1, 32'hffff_ffff), $urandom_range(1, 32'hffff_ffff),
                16'($urandom_range(1, 16'hffff)), 16'($urandom_range(1, 16'hffff)));
    for (int f = FLAW_NONE; f <= FLAW_DST_PORT; f++) send_frame(8, flaw_t'(f), FILL_RANDOM);
  endtask

  task automatic test_register_extremes();
    set_filters(32'hffff_ffff, 32'hffff_ffff, 16'hffff, 16'hffff);
    send_frame(9, FLAW_NONE, FILL_RANDOM);
    send_frame(8, FLAW_DST_IP, FILL_RANDOM);
    set_filters('0, '0, '0, '0);
    send_frame(8, FLAW_NONE, FILL_RANDOM);
  endtask

  task automatic test_random_traffic();
    int start;
    int pick;
    for (int phase = 0; phase < 5; phase++) begin
      set_filters(pick_reg(32), pick_reg(32), 16'(pick_reg(16)), 16'(pick_reg(16)));
      quiet = (phase == 2);
      start = sent_beats;
      while (sent_beats - start < 20) begin
        pick = $urandom_range(0, 99);
        if (pick < 60)
          send_frame(($urandom_range(0, 3) == 0) ? $urandom_range(11, 14) : $urandom_range(8, 10),
                     FLAW_NONE, FILL_RANDOM);
        else if (pick < 75)
          send_frame($urandom_range(8, 10),
                     flaw_t'($urandom_range(FLAW_ETHERTYPE, FLAW_DST_PORT)), FILL_RANDOM);
        else if (pick < 90)
          send_frame($urandom_range(1, 7), FLAW_NONE, FILL_RANDOM);
        else
          send_frame($urandom_range(1, 12), FLAW_NOISE, FILL_RANDOM);
      end
      quiet = 1'b0;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed_frames();
    test_header_checks();
    test_register_extremes();
    test_random_traffic();
    wait_idle();
    $display("sent %0d beats in short, flawed, noise and passing frames", sent_beats);
    $display("checked %0d keys and beats over %0d filter settings", checked_results,
             filter_settings);
    if (errors == 0 && filtered_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
